// ----- rtl/core/tlri_pkg.sv -----
// Package for the two-line relation and intersection block.
// Holds field widths, line kind codes and the sideband flags struct; no dependencies.
package tlri_pkg;

    localparam int COEF_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int SLOPE_W        = 32;
    localparam int POINT_W        = 48;

    localparam logic [1:0] KIND_SLOPED     = 2'd0;
    localparam logic [1:0] KIND_HORIZONTAL = 2'd1;
    localparam logic [1:0] KIND_VERTICAL   = 2'd2;

    // Flags that travel beside a division through the divider chain.
    typedef struct packed {
        logic [1:0] first_kind;
        logic [1:0] second_kind;
        logic       same_line;
        logic       is_parallel;
        logic       is_perpendicular;
        logic       has_point;
        logic       invalid;
    } tlri_flags_t;

endpackage

// ----- rtl/core/tlri_div_cell.sv -----
// One restoring-division cell: develops one quotient bit per cycle while en is high.
// Depends on nothing; chained by tlri_div_chain.
module tlri_div_cell #(
    parameter int NW = 64,
    parameter int DW = 32
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] num_in,
    input  logic [DW-1:0] den_in,
    input  logic [DW:0]   rem_in,
    output logic [NW-1:0] num_out,
    output logic [DW-1:0] den_out,
    output logic [DW:0]   rem_out
);
    logic [DW+1:0] shifted;
    logic [DW+1:0] diff;
    logic          take;

    assign shifted = {rem_in, num_in[NW-1]};
    assign diff    = shifted - {2'b00, den_in};
    assign take    = ~diff[DW+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_out <= take ? diff[DW:0] : shifted[DW:0];
            num_out <= {num_in[NW-2:0], take};
            den_out <= den_in;
        end
    end
endmodule

// ----- rtl/core/tlri_div_chain.sv -----
// Unsigned divider built as a row of tlri_div_cell, one quotient bit per cell.
// Result = floor(num/den) on NW bits; depends on tlri_div_cell.
module tlri_div_chain #(
    parameter int NW = 64,
    parameter int DW = 32
) (
    input  logic          aclk,
    input  logic [NW-1:0] en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo
);
    logic [NW-1:0] n_q [NW+1];
    logic [DW-1:0] d_q [NW+1];
    logic [DW:0]   r_q [NW+1];

    assign n_q[0] = num;
    assign d_q[0] = den;
    assign r_q[0] = '0;

    for (genvar i = 0; i < NW; i++) begin : g_cell
        tlri_div_cell #(.NW(NW), .DW(DW)) u_cell (
            .aclk(aclk), .en(en[i]),
            .num_in(n_q[i]), .den_in(d_q[i]), .rem_in(r_q[i]),
            .num_out(n_q[i+1]), .den_out(d_q[i+1]), .rem_out(r_q[i+1])
        );
    end

    assign quo = n_q[NW];
endmodule

// ----- rtl/core/two_line_relation_intersect.sv -----
// Top level of the two-line relation and intersection block.
// Depends on tlri_pkg and tlri_div_chain (a chain of tlri_div_cell).
//
// Usage: one transfer on the s_ channel carries two lines a*x+b*y=c; one
// transfer on the m_ channel returns the classification of each line, the
// slopes -a/b, the pair relations and the Cramer intersection point.
// The work runs through a pipeline: one product stage, one stage that forms
// the determinant and the numerators, then divider rows of one quotient bit
// per cell (as many cells as the widest quotient, numerator plus fraction
// bits), then a sign and saturation stage into the output register.
// Throughput is one transfer per cycle while the receiver does not stall:
// every stage advances together whenever the output register is empty or
// being taken, so a new item enters whenever the pipeline advances.
// When the receiver stalls, the whole pipeline holds; s_axis_tready drops
// only while the output register is full and not taken.
// Reset clears all valid bits; payload registers are not reset.
module two_line_relation_intersect
    import tlri_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // first_a, first_b, first_c, second_a, second_b, second_c from bit 0 up
    input  logic [((6*COEF_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // first_kind, second_kind, first_slope, second_slope, same_line,
    // is_parallel, is_perpendicular, has_point, point_x, point_y, invalid
    output logic [175:0] m_axis_tdata
);
    localparam int CW = COEF_WIDTH;
    localparam int PW = 2*CW + 1;          // determinant and numerator width
    localparam int QW = PW + FRAC_BITS;    // quotient bits
    localparam int SW = ((QW > POINT_W) ? QW : POINT_W) + 1;  // saturation width

    logic adv;
    assign adv = ~m_axis_tvalid | m_axis_tready;
    assign s_axis_tready = adv;

    logic signed [CW-1:0] a1, b1, c1, a2, b2, c2;
    assign a1 = s_axis_tdata[0*CW +: CW];
    assign b1 = s_axis_tdata[1*CW +: CW];
    assign c1 = s_axis_tdata[2*CW +: CW];
    assign a2 = s_axis_tdata[3*CW +: CW];
    assign b2 = s_axis_tdata[4*CW +: CW];
    assign c2 = s_axis_tdata[5*CW +: CW];

    // Stage 1: pairwise products, one multiplier each.
    logic v1_reg;
    logic signed [2*CW-1:0] p_a1b2_reg, p_a2b1_reg, p_a1c2_reg, p_a2c1_reg;
    logic signed [2*CW-1:0] p_b1c2_reg, p_b2c1_reg, p_c1b2_reg, p_a1a2_reg, p_b1b2_reg;
    logic signed [CW-1:0]   a1_reg, b1_reg, a2_reg, b2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_axis_tvalid;
        end
        if (adv) begin
            p_a1b2_reg <= a1 * b2;
            p_a2b1_reg <= a2 * b1;
            p_a1c2_reg <= a1 * c2;
            p_a2c1_reg <= a2 * c1;
            p_b1c2_reg <= b1 * c2;
            p_b2c1_reg <= b2 * c1;
            p_c1b2_reg <= c1 * b2;
            p_a1a2_reg <= a1 * a2;
            p_b1b2_reg <= b1 * b2;
            a1_reg <= a1; b1_reg <= b1; a2_reg <= a2; b2_reg <= b2;
        end
    end

    // Stage 2: determinant, numerators, flags and the four divisions' operands.
    logic signed [PW-1:0] det, nx, ny, perp_sum;
    logic bad1, bad2, bad, par;
    assign det  = PW'(p_a1b2_reg) - PW'(p_a2b1_reg);
    assign nx   = PW'(p_c1b2_reg) - PW'(p_b1c2_reg);
    assign ny   = PW'(p_a1c2_reg) - PW'(p_a2c1_reg);
    assign perp_sum = PW'(p_a1a2_reg) + PW'(p_b1b2_reg);
    assign bad1 = (a1_reg == '0) && (b1_reg == '0);
    assign bad2 = (a2_reg == '0) && (b2_reg == '0);
    assign bad  = bad1 | bad2;
    assign par  = (det == '0);

    function automatic logic [1:0] kind_of(input logic signed [CW-1:0] a,
                                           input logic signed [CW-1:0] b);
        if (a == '0 && b != '0) return KIND_HORIZONTAL;
        if (b == '0 && a != '0) return KIND_VERTICAL;
        return KIND_SLOPED;
    endfunction

    function automatic logic [PW-1:0] mag_of(input logic signed [PW-1:0] v);
        return v[PW-1] ? PW'(-v) : PW'(v);
    endfunction

    logic v2_reg;
    tlri_flags_t fl2_reg;
    logic [PW-1:0] mx_reg, my_reg, md_reg, ms1_reg, ms2_reg, mb1_reg, mb2_reg;
    logic negx_reg, negy_reg, negs1_reg, negs2_reg, zs1_reg, zs2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
        if (adv) begin
            fl2_reg.first_kind       <= kind_of(a1_reg, b1_reg);
            fl2_reg.second_kind      <= kind_of(a2_reg, b2_reg);
            fl2_reg.invalid          <= bad;
            fl2_reg.is_parallel      <= ~bad & par;
            fl2_reg.same_line        <= ~bad & par & (p_a1c2_reg == p_a2c1_reg)
                                        & (p_b1c2_reg == p_b2c1_reg);
            fl2_reg.is_perpendicular <= ~bad & (perp_sum == '0);
            fl2_reg.has_point        <= ~bad & ~par;
            mx_reg   <= mag_of(nx);
            my_reg   <= mag_of(ny);
            md_reg   <= mag_of(det);
            negx_reg <= nx[PW-1] ^ det[PW-1];
            negy_reg <= ny[PW-1] ^ det[PW-1];
            ms1_reg  <= mag_of(PW'(a1_reg));
            ms2_reg  <= mag_of(PW'(a2_reg));
            mb1_reg  <= mag_of(PW'(b1_reg));
            mb2_reg  <= mag_of(PW'(b2_reg));
            // slope = -a/b, so negative when a and b share a sign
            negs1_reg <= ~(a1_reg[CW-1] ^ b1_reg[CW-1]);
            negs2_reg <= ~(a2_reg[CW-1] ^ b2_reg[CW-1]);
            zs1_reg   <= (a1_reg == '0) | (b1_reg == '0);
            zs2_reg   <= (a2_reg == '0) | (b2_reg == '0);
        end
    end

    // Divider rows; sideband flags shift alongside.
    logic [QW-1:0] en;
    assign en = {QW{adv}};

    logic [QW-1:0] qx, qy, qs1, qs2;
    tlri_div_chain #(.NW(QW), .DW(PW)) u_div_x (.aclk(aclk), .en(en),
        .num(QW'(mx_reg) << FRAC_BITS), .den(md_reg), .quo(qx));
    tlri_div_chain #(.NW(QW), .DW(PW)) u_div_y (.aclk(aclk), .en(en),
        .num(QW'(my_reg) << FRAC_BITS), .den(md_reg), .quo(qy));
    tlri_div_chain #(.NW(QW), .DW(PW)) u_div_s1 (.aclk(aclk), .en(en),
        .num(QW'(ms1_reg) << FRAC_BITS), .den(mb1_reg), .quo(qs1));
    tlri_div_chain #(.NW(QW), .DW(PW)) u_div_s2 (.aclk(aclk), .en(en),
        .num(QW'(ms2_reg) << FRAC_BITS), .den(mb2_reg), .quo(qs2));

    localparam int SBW = $bits(tlri_flags_t) + 6;
    logic [SBW-1:0] sb_reg [QW];
    logic [QW-1:0]  vd_reg;
    logic [SBW-1:0] sb_in;
    assign sb_in = {fl2_reg, negx_reg, negy_reg, negs1_reg, negs2_reg, zs1_reg, zs2_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= '0;
        end else if (adv) begin
            vd_reg <= {vd_reg[QW-2:0], v2_reg};
        end
        if (adv) begin
            sb_reg[0] <= sb_in;
            for (int i = 1; i < QW; i++) sb_reg[i] <= sb_reg[i-1];
        end
    end

    // Sign and saturation.
    tlri_flags_t fl;
    logic nx_s, ny_s, n1_s, n2_s, z1_s, z2_s;
    assign {fl, nx_s, ny_s, n1_s, n2_s, z1_s, z2_s} = sb_reg[QW-1];

    function automatic logic [POINT_W-1:0] sat_pt(input logic [QW-1:0] q,
                                                  input logic neg);
        logic [SW-1:0] lim;
        logic [SW-1:0] v;
        lim = (SW'(1) << (POINT_W-1)) - (neg ? SW'(0) : SW'(1));
        v   = SW'(q);
        if (v > lim) v = lim;
        if (neg) v = -v;
        return v[POINT_W-1:0];
    endfunction

    function automatic logic [SLOPE_W-1:0] sat_sl(input logic [QW-1:0] q,
                                                  input logic neg);
        logic [SW-1:0] lim;
        logic [SW-1:0] v;
        lim = (SW'(1) << (SLOPE_W-1)) - (neg ? SW'(0) : SW'(1));
        v   = SW'(q);
        if (v > lim) v = lim;
        if (neg) v = -v;
        return v[SLOPE_W-1:0];
    endfunction

    logic [175:0] out_next;
    always_comb begin
        out_next = '0;
        out_next[1:0]   = fl.first_kind;
        out_next[3:2]   = fl.second_kind;
        out_next[35:4]  = z1_s ? '0 : sat_sl(qs1, n1_s);
        out_next[67:36] = z2_s ? '0 : sat_sl(qs2, n2_s);
        out_next[68]    = fl.same_line;
        out_next[69]    = fl.is_parallel;
        out_next[70]    = fl.is_perpendicular;
        out_next[71]    = fl.has_point;
        out_next[119:72]  = fl.has_point ? sat_pt(qx, nx_s) : '0;
        out_next[167:120] = fl.has_point ? sat_pt(qy, ny_s) : '0;
        out_next[168]   = fl.invalid;
    end

    logic [175:0] m_data_reg;
    logic         m_valid_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= vd_reg[QW-1];
        end
        if (adv) m_data_reg <= out_next;
    end
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output changed while stalled");
    a_pt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[71] |-> m_axis_tdata[119:72] == '0)
        else $error("point without has_point");
    a_inv: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[168] |-> m_axis_tdata[71:68] == '0)
        else $error("relation flags with invalid line");
endmodule

// ----- test/two_line_relation_intersect_chk.sv -----
// Checker for the two-line relation and intersection block.
// Watches both stream channels, predicts each result and compares it; uses tlri_pkg.
module two_line_relation_intersect_chk
    import tlri_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [175:0] m_axis_tdata,
    output int           fail_count,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = FRAC_BITS_DEF;

    typedef struct packed {
        logic               invalid;
        logic signed [47:0] point_y;
        logic signed [47:0] point_x;
        logic               has_point;
        logic               is_perpendicular;
        logic               is_parallel;
        logic               same_line;
        logic signed [31:0] second_slope;
        logic signed [31:0] first_slope;
        logic [1:0]         second_kind;
        logic [1:0]         first_kind;
    } relation_t;

    relation_t expected_relations[$];

    // Signed quotient num/den scaled by 2^FB, truncated toward zero,
    // saturated to w bits.
    function automatic logic signed [63:0] scaled_quotient(
        longint num, longint den, int w);
        logic       neg;
        logic [127:0] un, ud, q, lim;
        if (den == 0) return 0;
        neg = (num < 0) != (den < 0);
        un = (num < 0) ? -num : num;
        ud = (den < 0) ? -den : den;
        q = (un << FB) / ud;
        lim = (128'd1 << (w - 1)) - (neg ? 0 : 1);
        if (q > lim) q = lim;
        return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    function automatic logic [1:0] kind_of(longint a, longint b);
        if (a == 0 && b != 0) return KIND_HORIZONTAL;
        if (b == 0 && a != 0) return KIND_VERTICAL;
        return KIND_SLOPED;
    endfunction

    function automatic logic signed [31:0] slope_of(longint a, longint b);
        logic signed [63:0] s;
        if (a == 0 || b == 0) return 0;
        s = scaled_quotient(-a, b, 32);
        return s[31:0];
    endfunction

    function automatic relation_t predict_relation(logic [95:0] d);
        relation_t r;
        longint a1, b1, c1, a2, b2, c2, det;
        logic signed [63:0] q;
        a1 = $signed(d[15:0]);  b1 = $signed(d[31:16]); c1 = $signed(d[47:32]);
        a2 = $signed(d[63:48]); b2 = $signed(d[79:64]); c2 = $signed(d[95:80]);
        r = '0;
        r.first_kind   = kind_of(a1, b1);
        r.second_kind  = kind_of(a2, b2);
        r.first_slope  = slope_of(a1, b1);
        r.second_slope = slope_of(a2, b2);
        r.invalid = (a1 == 0 && b1 == 0) || (a2 == 0 && b2 == 0);
        det = a1 * b2 - a2 * b1;
        if (!r.invalid) begin
            r.is_parallel = (det == 0);
            r.same_line = r.is_parallel && (a1 * c2 == a2 * c1) && (b1 * c2 == b2 * c1);
            r.is_perpendicular = (a1 * a2 + b1 * b2 == 0);
            r.has_point = !r.is_parallel;
            if (r.has_point) begin
                q = scaled_quotient(c1 * b2 - c2 * b1, det, 48);
                r.point_x = q[47:0];
                q = scaled_quotient(a1 * c2 - a2 * c1, det, 48);
                r.point_y = q[47:0];
            end
        end
        return r;
    endfunction

    assign pending = expected_relations.size();

    initial fail_count = 0;

    always @(posedge aclk) begin
        relation_t e, g;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                expected_relations.push_back(predict_relation(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                g = m_axis_tdata[168:0];
                if (expected_relations.size() == 0) begin
                    $error("unexpected result transfer");
                    fail_count++;
                end else begin
                    e = expected_relations.pop_front();
                    if (e.first_kind !== g.first_kind) begin
                        $error("first_kind exp %0d got %0d", e.first_kind, g.first_kind);
                        fail_count++;
                    end
                    if (e.second_kind !== g.second_kind) begin
                        $error("second_kind exp %0d got %0d", e.second_kind, g.second_kind);
                        fail_count++;
                    end
                    if (e.first_slope !== g.first_slope) begin
                        $error("first_slope exp %0d got %0d", e.first_slope, g.first_slope);
                        fail_count++;
                    end
                    if (e.second_slope !== g.second_slope) begin
                        $error("second_slope exp %0d got %0d", e.second_slope,
                               g.second_slope);
                        fail_count++;
                    end
                    if (e.same_line !== g.same_line) begin
                        $error("same_line exp %0d got %0d", e.same_line, g.same_line);
                        fail_count++;
                    end
                    if (e.is_parallel !== g.is_parallel) begin
                        $error("is_parallel exp %0d got %0d", e.is_parallel, g.is_parallel);
                        fail_count++;
                    end
                    if (e.is_perpendicular !== g.is_perpendicular) begin
                        $error("is_perpendicular exp %0d got %0d", e.is_perpendicular,
                               g.is_perpendicular);
                        fail_count++;
                    end
                    if (e.has_point !== g.has_point) begin
                        $error("has_point exp %0d got %0d", e.has_point, g.has_point);
                        fail_count++;
                    end
                    if (e.point_x !== g.point_x) begin
                        $error("point_x exp %0d got %0d", e.point_x, g.point_x);
                        fail_count++;
                    end
                    if (e.point_y !== g.point_y) begin
                        $error("point_y exp %0d got %0d", e.point_y, g.point_y);
                        fail_count++;
                    end
                    if (e.invalid !== g.invalid) begin
                        $error("invalid exp %0d got %0d", e.invalid, g.invalid);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

// ----- test/two_line_relation_intersect_tb.sv -----
// Testbench top for the two-line relation and intersection block.
// Drives line pairs and the result stall; needs the block and its checker.
module two_line_relation_intersect_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [175:0] m_axis_tdata;
    int           fail_count;
    int           pending;

    // Receiver stall control: random bursts, a long hold-off, none at the end.
    bit quiet_phase = 0;
    bit long_hold = 0;

    always #4 aclk = ~aclk;

    two_line_relation_intersect dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    two_line_relation_intersect_chk chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    // Picks a coefficient: extremes, zero and small values are favored so
    // that degenerate, parallel and perpendicular pairs come up often.
    function automatic logic [15:0] pick_coef();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(0, 6)) - 3);
            4, 5: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 200)) - 100);
        endcase
    endfunction

    // Builds a random pair, often with the second line derived from the first.
    function automatic logic [95:0] random_pair();
        logic signed [15:0] a1, b1, c1, a2, b2, c2, k;
        a1 = pick_coef(); b1 = pick_coef(); c1 = pick_coef();
        a2 = pick_coef(); b2 = pick_coef(); c2 = pick_coef();
        k = 16'($signed($urandom_range(0, 6)) - 3);
        case ($urandom_range(0, 5))
            0: begin a2 = a1 * k; b2 = b1 * k; c2 = c1 * k; end
            1: begin a2 = a1 * k; b2 = b1 * k; end
            2: begin a2 = -b1 * k; b2 = a1 * k; end
            default: ;
        endcase
        return {c2, b2, a2, c1, b1, a1};
    endfunction

    // Offers one pair and holds it until the transfer completes, with an
    // optional random gap beforehand during which nothing is offered.
    task automatic send_pair(logic [95:0] d, bit gaps);
        if (gaps && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= d;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    task automatic send_back_to_back(logic [95:0] d);
        s_axis_tvalid <= 1;
        s_axis_tdata  <= d;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn || long_hold)
            m_axis_tready <= 0;
        else if (quiet_phase)
            m_axis_tready <= 1;
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    // Receiver hold-off counted in cycles, so the pipeline fills and the
    // input side stalls while the sender keeps offering.
    initial begin
        wait (aresetn);
        repeat (40) @(posedge aclk);
        long_hold = 1;
        repeat (300) @(posedge aclk);
        long_hold = 0;
    end

    initial begin
        logic [95:0] dir[$];
        dir.push_back({16'sd5, 16'sd1, 16'sd1, 16'sd3, 16'sd1, 16'sd1});
        dir.push_back({16'sd7, 16'sd2, 16'sd4, 16'sd3, 16'sd1, 16'sd2});
        dir.push_back({16'sd1, 16'sd0, 16'sd1, 16'sd4, 16'sd2, 16'sd0});
        dir.push_back({16'sd2, 16'sd1, 16'sd0, 16'sd3, 16'sd0, 16'sd5});
        dir.push_back({16'sd1, 16'sd0, 16'sd0, 16'sd3, 16'sd1, 16'sd1});
        dir.push_back({16'sd1, 16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd0});
        dir.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
        dir.push_back({16'sd1, 16'sd1, 16'sd2, 16'sd5, 16'sd1, 16'h8000});
        dir.push_back({16'sd1, 16'sd2, 16'sd1, 16'sd5, 16'sd1, 16'h7fff});
        dir.push_back({16'h8000, 16'h7fff, 16'sd1, 16'h7fff, 16'h8000, 16'h7fff});
        dir.push_back({16'h7fff, 16'sd1, 16'sd1, 16'h8000, 16'h7fff, 16'sd1});
        dir.push_back({16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
        dir.push_back({16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff});
        dir.push_back({16'h7fff, 16'sd1, 16'sd0, 16'h7fff, 16'sd0, 16'sd1});
        dir.push_back({16'h7fff, 16'h7fff, 16'h8000, 16'sd0, 16'sd1, 16'sd1});
        dir.push_back({16'sd6, 16'sd4, 16'sd2, 16'sd3, 16'sd2, 16'sd1});
        dir.push_back({16'sd3, 16'sd2, 16'sd1, 16'sd9, 16'sd2, 16'sd1});
        dir.push_back({16'sd0, 16'sd1, 16'sd0, 16'sd7, 16'sd0, 16'sd1});
        dir.push_back({16'sd0, 16'sd0, 16'sd9, 16'sd1, 16'sd0, 16'sd0});

        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        foreach (dir[i]) send_pair(dir[i], 1);
        // Keep offering during the long receiver hold-off.
        repeat (150) send_back_to_back(random_pair());
        s_axis_tvalid <= 0;
        // Sender pause until every expected result has come.
        while (pending != 0) @(posedge aclk);
        repeat (300) send_pair(random_pair(), 1);
        // Last part of the run: no idling on either side.
        quiet_phase = 1;
        repeat (200) send_back_to_back(random_pair());
        s_axis_tvalid <= 0;

        while (pending != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #2ms;
        $display("tb: failure");
        $finish;
    end
endmodule
